// ===== rtl/core/irud_pkg.sv =====
// shared types and constants for the ir/ultrasonic docking controller
`default_nettype none

package irud_pkg;

  // field widths
  localparam int unsigned DIST_W  = 12;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned CMD_W   = 3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_THRESHOLD = 1'd0,
    CFG_DRIVE_SPEED    = 1'd1
  } cfg_reg_t;

  // register and state reset values
  localparam logic [DIST_W-1:0]  NEAR_THRESHOLD_RST = 12'd7;
  localparam logic [SPEED_W-1:0] DRIVE_SPEED_RST    = 16'd1000;
  localparam logic [DIST_W-1:0]  WINDOW_RST         = 12'd100;

  // motor command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_NONE    = 3'd0,
    CMD_STOP    = 3'd1,
    CMD_FORWARD = 3'd2,
    CMD_BACK    = 3'd3,
    CMD_LEFT    = 3'd4,
    CMD_RIGHT   = 3'd5
  } motor_cmd_t;

endpackage : irud_pkg

`default_nettype wire

// ===== rtl/core/ir_ultrasonic_docking_controller.sv =====
// ir/ultrasonic docking controller top level: sample window, dock detect, steering
// path: an accepted request waits in the input register, then one pass of window update,
//   compare and steering logic writes the result register; a result left waiting stalls it
// throughput: one request per cycle while the result drains; the input register refills as it leaves
// reset: synchronous active-low rst_n restores the registers, both windows to 100,
//   the fill index to the top slot, capture on, both arms set and no turn latched
`default_nettype none

module ir_ultrasonic_docking_controller
  import irud_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 3
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // request channel
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [DIST_W-1:0]     in_distance,
  input  wire                   in_ir_left,
  input  wire                   in_ir_right,
  input  wire                   in_ir_front_left,
  input  wire                   in_ir_front_middle,
  input  wire                   in_ir_front_right,
  // result channel
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [CMD_W-1:0]      out_motor_command,
  output logic [SPEED_W-1:0]    out_motor_speed,
  output logic                  out_docked,
  // configuration writes
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_wdata
);

  // fill index is wide enough to address every slot, one bit minimum
  localparam int unsigned FIDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [FIDX_W-1:0] FIDX_TOP = FIDX_W'(WINDOW_LEN - 1);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]  near_threshold_r;
  logic [SPEED_W-1:0] drive_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_threshold_r <= NEAR_THRESHOLD_RST;
      drive_speed_r    <= DRIVE_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NEAR_THRESHOLD: near_threshold_r <= cfg_wdata[DIST_W-1:0];
        CFG_DRIVE_SPEED:    drive_speed_r    <= cfg_wdata[SPEED_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register stage
  // ---------------------------------------------------------------------------
  logic              in_valid_r;
  logic [DIST_W-1:0] dist_r;
  logic              ir_l_r, ir_r_r, ir_fl_r, ir_fm_r, ir_fr_r;
  logic              out_valid_r;
  logic              adv;      // stage request moves into the result register
  logic              in_take;  // new request captured

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload holds while the stage is occupied and stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      dist_r  <= in_distance;
      ir_l_r  <= in_ir_left;
      ir_r_r  <= in_ir_right;
      ir_fl_r <= in_ir_front_left;
      ir_fm_r <= in_ir_front_middle;
      ir_fr_r <= in_ir_front_right;
    end
  end

  // ---------------------------------------------------------------------------
  // controller state
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0] sample_r    [WINDOW_LEN];
  logic [DIST_W-1:0] committed_r [WINDOW_LEN];
  logic [FIDX_W-1:0] fill_idx_r;
  logic              capture_en_r;
  logic              right_arm_r, left_arm_r;
  logic              turn_right_r, turn_left_r;

  logic [DIST_W-1:0] sample_nxt    [WINDOW_LEN];
  logic [DIST_W-1:0] committed_nxt [WINDOW_LEN];
  logic [FIDX_W-1:0] fill_idx_nxt;
  logic              capture_en_nxt;
  logic              right_arm_nxt, left_arm_nxt;
  logic              turn_right_nxt, turn_left_nxt;
  logic              docked_c;
  motor_cmd_t        cmd_c;

  // window capture: slots fill from the top down, the bottom write commits
  always_comb begin
    for (int k = 0; k < WINDOW_LEN; k++) begin
      sample_nxt[k]    = sample_r[k];
      committed_nxt[k] = committed_r[k];
    end
    fill_idx_nxt = fill_idx_r;
    if (capture_en_r) begin
      sample_nxt[fill_idx_r] = dist_r;
      if (fill_idx_r == '0) begin
        fill_idx_nxt = FIDX_TOP;
        for (int k = 0; k < WINDOW_LEN; k++) begin
          committed_nxt[k] = sample_nxt[k];
        end
      end else begin
        fill_idx_nxt = fill_idx_r - 1'b1;
      end
    end
  end

  // docked when every committed distance is strictly below the threshold
  always_comb begin
    docked_c = 1'b1;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      if (!(committed_nxt[k] < near_threshold_r)) begin
        docked_c = 1'b0;
      end
    end
  end

  // steering decision
  always_comb begin
    capture_en_nxt = capture_en_r;
    right_arm_nxt  = right_arm_r;
    left_arm_nxt   = left_arm_r;
    turn_right_nxt = turn_right_r;
    turn_left_nxt  = turn_left_r;
    cmd_c          = CMD_NONE;
    if (docked_c) begin
      // stop and freeze capture so the committed window stays put
      capture_en_nxt = 1'b0;
      cmd_c          = CMD_STOP;
    end else begin
      capture_en_nxt = 1'b1;
      // a side beacon latches a turn while its arm is still set
      turn_right_nxt = turn_right_r || (ir_r_r && right_arm_r);
      turn_left_nxt  = turn_left_r  || (ir_l_r && left_arm_r);
      if (turn_right_nxt || turn_left_nxt) begin
        // both latched: right wins only if the right beacon is seen now
        if (turn_right_nxt && turn_left_nxt) begin
          if (ir_r_r) begin
            turn_left_nxt = 1'b0;
          end else begin
            turn_right_nxt = 1'b0;
          end
        end
        cmd_c = turn_right_nxt ? CMD_RIGHT : CMD_LEFT;
        // all front beacons aligned: end the turn, disarm, back in
        if (ir_fl_r && ir_fm_r && ir_fr_r) begin
          turn_right_nxt = 1'b0;
          turn_left_nxt  = 1'b0;
          right_arm_nxt  = 1'b0;
          left_arm_nxt   = 1'b0;
          cmd_c          = CMD_BACK;
        end
      end else if (!right_arm_r && !left_arm_r) begin
        // disarmed approach: front pattern centers the robot
        if (ir_fm_r) begin
          if (ir_fl_r == ir_fr_r) begin
            cmd_c = CMD_BACK;
          end else if (ir_fr_r) begin
            cmd_c = CMD_RIGHT;
          end else begin
            cmd_c = CMD_LEFT;
          end
        end
      end else begin
        cmd_c = CMD_FORWARD;
      end
    end
  end

  // state advances once per request, as it leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        sample_r[k]    <= WINDOW_RST;
        committed_r[k] <= WINDOW_RST;
      end
      fill_idx_r   <= FIDX_TOP;
      capture_en_r <= 1'b1;
      right_arm_r  <= 1'b1;
      left_arm_r   <= 1'b1;
      turn_right_r <= 1'b0;
      turn_left_r  <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        sample_r[k]    <= sample_nxt[k];
        committed_r[k] <= committed_nxt[k];
      end
      fill_idx_r   <= fill_idx_nxt;
      capture_en_r <= capture_en_nxt;
      right_arm_r  <= right_arm_nxt;
      left_arm_r   <= left_arm_nxt;
      turn_right_r <= turn_right_nxt;
      turn_left_r  <= turn_left_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [CMD_W-1:0]   out_cmd_r;
  logic [SPEED_W-1:0] out_speed_r;
  logic               out_docked_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cmd_r    <= cmd_c;
      // speed only rides along with motion commands
      out_speed_r  <= (cmd_c == CMD_NONE || cmd_c == CMD_STOP) ? '0 : drive_speed_r;
      out_docked_r <= docked_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_motor_command = out_cmd_r;
  assign out_motor_speed   = out_speed_r;
  assign out_docked        = out_docked_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_one_turn: assert property (@(posedge clk) disable iff (!rst_n)
    !(turn_right_r && turn_left_r))
    else $error("both turn directions latched");

  a_arms_stay_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (!right_arm_r && !left_arm_r) |=> (!right_arm_r && !left_arm_r))
    else $error("arm re-armed without reset");

  a_dock_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && docked_c) |=> (!capture_en_r && out_valid_r && out_docked_r))
    else $error("docked request did not stop capture");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_idx_r <= FIDX_TOP)
    else $error("fill index beyond window");

  a_dock_means_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_docked_r) |-> (out_cmd_r == CMD_STOP && out_speed_r == '0))
    else $error("docked result without stop");

endmodule : ir_ultrasonic_docking_controller

`default_nettype wire
